FILE: src/sliding_window_timing_stats_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef SLIDING_WINDOW_TIMING_STATS_ASSERT_SVH
`define SLIDING_WINDOW_TIMING_STATS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sliding window stats check failed");

// Consequent must hold in the cycle after the antecedent.
`define SWTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sliding window stats check failed");

`endif

FILE: src/swts_pkg.sv
package swts_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int TIME_W      = 32;
    localparam int SAMPLE_W    = 31;
    localparam int COUNT_OUT_W = 7;

    // Input command codes.
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Result series codes.
    localparam logic [1:0] SER_CPU = 2'd0;
    localparam logic [1:0] SER_GPU = 2'd1;
    localparam logic [1:0] SER_SUM = 2'd2;

    // Work handed from the front to the back through the queue.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_QUERY,
        OP_DISABLED_QUERY,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [SAMPLE_W-1:0] cpu;
        logic [SAMPLE_W-1:0] gpu;
    } t_work;

endpackage

FILE: src/swts_queue.sv
module swts_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  swts_pkg::t_work i_data,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output swts_pkg::t_work o_data
);
    import swts_pkg::*;

    t_work      r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_used;
    logic       push_ok;
    logic       pop_ok;

    assign o_full  = (r_used == 2'd2);
    assign o_valid = (r_used != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_used   <= 2'd0;
        end else begin
            if (push_ok) begin
                r_slot[r_wr_ptr] <= i_data;
                r_wr_ptr         <= ~r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_used <= r_used + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

endmodule

FILE: src/swts_front.sv
module swts_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_command,
    input  logic [31:0]   i_cpu_time,
    input  logic [31:0]   i_gpu_time,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    input  logic          i_full,
    output logic          o_push,
    output swts_pkg::t_work o_work
);
    import swts_pkg::*;

    logic r_enable;
    logic accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_data;
        end
    end

    // Rejected adds and the unused command are dropped here.
    always_comb begin
        o_work.cpu = i_cpu_time[SAMPLE_W-1:0];
        o_work.gpu = i_gpu_time[SAMPLE_W-1:0];
        o_work.op  = OP_ADD;
        o_push     = 1'b0;
        unique case (i_command)
            CMD_ADD: begin
                o_push = accept && r_enable && !i_cpu_time[31] && !i_gpu_time[31];
            end
            CMD_QUERY: begin
                o_push    = accept;
                o_work.op = r_enable ? OP_QUERY : OP_DISABLED_QUERY;
            end
            CMD_CLEAR: begin
                o_push    = accept;
                o_work.op = OP_CLEAR;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

FILE: src/swts_div.sv
module swts_div #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int NCW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [NCW-1:0]   r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   shifted;
    logic             fits;

    // One quotient bit per cycle, restoring form.
    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign fits    = (shifted >= {1'b0, r_den});
    assign o_done  = r_done;
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= NCW'(NUM_W);
            r_rem  <= '0;
            r_quo  <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(shifted - {1'b0, r_den}) : shifted[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == NCW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

FILE: src/swts_back.sv
module swts_back #(
    parameter int DEPTH = swts_pkg::DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_work_valid,
    input  swts_pkg::t_work i_work,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_series,
    output logic            o_valid_res,
    output logic [31:0]     o_mean_value,
    output logic [31:0]     o_minimum_value,
    output logic [31:0]     o_maximum_value,
    output logic [31:0]     o_median_value,
    output logic [6:0]      o_sample_count,
    output logic            o_last_result
);
    import swts_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SUMW = TIME_W + CW;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CAND,
        S_CWAIT,
        S_CMP,
        S_DIV,
        S_OUT
    } t_state;

    logic [SAMPLE_W-1:0] r_cpu_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_gpu_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rd_cpu;
    logic [SAMPLE_W-1:0] r_rd_gpu;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   r_oldest;
    logic [1:0]      r_ser;
    logic [CW-1:0]   r_i;
    logic [CW-1:0]   r_a;
    logic            r_dv;
    logic [SUMW-1:0] r_sum;
    logic [31:0]     r_min;
    logic [31:0]     r_max;
    logic [31:0]     r_cand;
    logic [CW-1:0]   r_lt;
    logic [CW-1:0]   r_le;
    logic [31:0]     r_med1;
    logic [31:0]     r_med2;
    logic            r_div_start;

    logic            out_free;
    logic            inv_work;
    logic            out_load;
    logic            scan_done;
    logic [CW-1:0]   rd_off;
    logic [CW:0]     rd_sum;
    logic [AW-1:0]   rd_addr;
    logic [CW:0]     wr_sum;
    logic [AW-1:0]   wr_addr;
    logic            do_write;
    logic [31:0]     v;
    logic [CW-1:0]   k1;
    logic [CW-1:0]   k2;
    logic [31:0]     med;
    logic            div_done;
    logic [SUMW-1:0] div_quo;

    // Only an invalid answer needs the output register at pop time; adds,
    // clears and real queries can start while a result word still waits.
    assign out_free  = !o_valid || i_ready;
    assign inv_work  = (i_work.op == OP_DISABLED_QUERY) ||
                       ((i_work.op == OP_QUERY) && (r_count == '0));
    assign o_pop     = (r_state == S_IDLE) && i_work_valid && (out_free || !inv_work);
    assign out_load  = (o_pop && inv_work) || ((r_state == S_OUT) && out_free);
    assign scan_done = (r_i == r_count) && !r_dv;
    assign do_write  = o_pop && (i_work.op == OP_ADD);

    // Circular slot arithmetic: oldest plus an offset below twice the depth.
    assign rd_off  = (r_state == S_CAND) ? r_a : r_i;
    assign rd_sum  = (CW+1)'(r_oldest) + (CW+1)'(rd_off);
    assign rd_addr = (rd_sum >= (CW+1)'(DEPTH)) ? AW'(rd_sum - (CW+1)'(DEPTH)) : AW'(rd_sum);
    // A full window writes at the oldest slot, which this also yields.
    assign wr_sum  = (CW+1)'(r_oldest) + (CW+1)'(r_count);
    assign wr_addr = (wr_sum >= (CW+1)'(DEPTH)) ? AW'(wr_sum - (CW+1)'(DEPTH)) : AW'(wr_sum);

    always_comb begin
        case (r_ser)
            SER_CPU: v = {1'b0, r_rd_cpu};
            SER_GPU: v = {1'b0, r_rd_gpu};
            default: v = 32'(r_rd_cpu) + 32'(r_rd_gpu);
        endcase
    end

    assign k1  = (r_count - 1'b1) >> 1;
    assign k2  = r_count >> 1;
    assign med = r_count[0] ? r_med2 : 32'(({1'b0, r_med1} + {1'b0, r_med2}) >> 1);

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_cpu_mem[wr_addr] <= i_work.cpu;
            r_gpu_mem[wr_addr] <= i_work.gpu;
        end
        r_rd_cpu <= r_cpu_mem[rd_addr];
        r_rd_gpu <= r_gpu_mem[rd_addr];
    end

    swts_div #(
        .NUM_W (SUMW),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_sum),
        .i_den   (r_count),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_oldest    <= '0;
            r_ser       <= SER_CPU;
            r_i         <= '0;
            r_a         <= '0;
            r_dv        <= 1'b0;
            r_div_start <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (out_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (i_work.op)
                            OP_ADD: begin
                                if (r_count == DEPTH_C) begin
                                    r_oldest <= (r_oldest == LAST_SLOT) ? '0 : r_oldest + 1'b1;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            OP_CLEAR: begin
                                r_count  <= '0;
                                r_oldest <= '0;
                            end
                            OP_QUERY, OP_DISABLED_QUERY: begin
                                if (i_work.op == OP_QUERY && r_count != '0) begin
                                    r_ser   <= SER_CPU;
                                    r_i     <= '0;
                                    r_dv    <= 1'b0;
                                    r_sum   <= '0;
                                    r_min   <= '1;
                                    r_max   <= '0;
                                    r_state <= S_SCAN;
                                end else begin
                                    o_series        <= SER_CPU;
                                    o_valid_res     <= 1'b0;
                                    o_mean_value    <= '0;
                                    o_minimum_value <= '0;
                                    o_maximum_value <= '0;
                                    o_median_value  <= '0;
                                    o_sample_count  <= COUNT_OUT_W'(r_count);
                                    o_last_result   <= 1'b1;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_dv <= (r_i != r_count);
                    if (r_i != r_count) begin
                        r_i <= r_i + 1'b1;
                    end
                    if (r_dv) begin
                        r_sum <= r_sum + SUMW'(v);
                        if (v < r_min) r_min <= v;
                        if (v > r_max) r_max <= v;
                    end
                    if (scan_done) begin
                        r_div_start <= 1'b1;
                        r_a         <= '0;
                        r_state     <= S_CAND;
                    end
                end
                S_CAND: begin
                    r_state <= S_CWAIT;
                end
                S_CWAIT: begin
                    r_cand  <= v;
                    r_i     <= '0;
                    r_dv    <= 1'b0;
                    r_lt    <= '0;
                    r_le    <= '0;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_dv <= (r_i != r_count);
                    if (r_i != r_count) begin
                        r_i <= r_i + 1'b1;
                    end
                    if (r_dv) begin
                        if (v < r_cand)  r_lt <= r_lt + 1'b1;
                        if (v <= r_cand) r_le <= r_le + 1'b1;
                    end
                    if (scan_done) begin
                        if (r_lt <= k1 && k1 < r_le) r_med1 <= r_cand;
                        if (r_lt <= k2 && k2 < r_le) r_med2 <= r_cand;
                        if (r_a == r_count - 1'b1) begin
                            r_state <= S_DIV;
                        end else begin
                            r_a     <= r_a + 1'b1;
                            r_state <= S_CAND;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        o_series        <= r_ser;
                        o_valid_res     <= 1'b1;
                        o_mean_value    <= div_quo[31:0];
                        o_minimum_value <= r_min;
                        o_maximum_value <= r_max;
                        o_median_value  <= med;
                        o_sample_count  <= COUNT_OUT_W'(r_count);
                        o_last_result   <= (r_ser == SER_SUM);
                        if (r_ser == SER_SUM) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ser   <= r_ser + 1'b1;
                            r_i     <= '0;
                            r_dv    <= 1'b0;
                            r_sum   <= '0;
                            r_min   <= '1;
                            r_max   <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/sliding_window_timing_stats.sv
// An add or clear enters the queue when accepted and reaches the window when the idle back pops it.
// A query walks the window per series for sum, minimum and maximum, then again for each held pair
// as median candidate while the 39-step mean divider runs; it returns three result words.
// An invalid query answers with one result word, loaded into the output register when the back pops it.
// Throughput: one add or clear per cycle while the back is idle and the queue has room.
// Reset: synchronous active low; window empty, collection disabled, no memory clear pass.
module sliding_window_timing_stats #(
    parameter int WINDOW_DEPTH = swts_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_cpu_time,
    input  logic [31:0] i_gpu_time,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_series,
    output logic        o_valid_res,
    output logic [31:0] o_mean_value,
    output logic [31:0] o_minimum_value,
    output logic [31:0] o_maximum_value,
    output logic [31:0] o_median_value,
    output logic [6:0]  o_sample_count,
    output logic        o_last_result
);
    import swts_pkg::*;

    // The front checks each word against the enable register and the sign
    // of both times, then pushes the surviving work into a two-entry queue.
    // The back owns the window memories, the fill count and the oldest slot,
    // and walks the window for queries while new words keep queueing.
    logic  push;
    logic  full;
    logic  work_valid;
    logic  pop;
    t_work push_work;
    t_work pop_work;

    swts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_cpu_time (i_cpu_time),
        .i_gpu_time (i_gpu_time),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .o_push     (push),
        .o_work     (push_work)
    );

    swts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_work),
        .o_full  (full),
        .o_valid (work_valid),
        .i_pop   (pop),
        .o_data  (pop_work)
    );

    // The back's output register lets the next query start its walk while
    // the previous result word still waits for the consumer.
    swts_back #(
        .DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_work_valid    (work_valid),
        .i_work          (pop_work),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_series        (o_series),
        .o_valid_res     (o_valid_res),
        .o_mean_value    (o_mean_value),
        .o_minimum_value (o_minimum_value),
        .o_maximum_value (o_maximum_value),
        .o_median_value  (o_median_value),
        .o_sample_count  (o_sample_count),
        .o_last_result   (o_last_result)
    );

endmodule

FILE: src/swts_checker.sv
`include "sliding_window_timing_stats_assert.svh"

module swts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_series,
    input logic        o_valid_res,
    input logic [31:0] o_mean_value,
    input logic [31:0] o_minimum_value,
    input logic [31:0] o_maximum_value,
    input logic [31:0] o_median_value,
    input logic        o_last_result
);
    import swts_pkg::*;

    // A stalled result word must not change under the consumer.
    `SWTS_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_series) && $stable(o_mean_value) && $stable(o_median_value))

    // An invalid answer is a single last word of the CPU series with zero mean and median.
    `SWTS_ASSERT_NOW(a_invalid_word, o_valid && !o_valid_res, o_last_result && o_series == SER_CPU && o_mean_value == 32'd0 && o_median_value == 32'd0)

    // Mean and median always lie between minimum and maximum.
    `SWTS_ASSERT_NOW(a_stat_order, o_valid && o_valid_res, o_minimum_value <= o_median_value && o_median_value <= o_maximum_value && o_minimum_value <= o_mean_value && o_mean_value <= o_maximum_value)

    // Only the total series closes a valid query.
    `SWTS_ASSERT_NOW(a_last_word, o_valid && o_valid_res, o_last_result == (o_series == SER_SUM))

endmodule

bind sliding_window_timing_stats swts_checker u_swts_checker (.*);
